@@ hw/rtl/ekl_pkg.sv @@
`timescale 1ns / 1ps

package ekl_pkg;

	// Reset brightness
	localparam logic [7:0] DEFAULT_LEVEL = 8'd128;

	// Saturation value of the tick counters
	localparam logic [10:0] TICK_MAX = 11'h7FF;

	// Configuration register indexes
	localparam logic [2:0] REG_PULSES_PER_STEP     = 3'd0;
	localparam logic [2:0] REG_STEP_SIZE           = 3'd1;
	localparam logic [2:0] REG_BRIGHTNESS_FLOOR    = 3'd2;
	localparam logic [2:0] REG_BRIGHTNESS_CEILING  = 3'd3;
	localparam logic [2:0] REG_DEBOUNCE_TICKS      = 3'd4;
	localparam logic [2:0] REG_SEND_INTERVAL_TICKS = 3'd5;

	// Configuration reset values
	localparam logic [2:0] PPS_RESET      = 3'd4;
	localparam logic [7:0] STEP_RESET     = 8'd8;
	localparam logic [7:0] FLOOR_RESET    = 8'd1;
	localparam logic [7:0] CEILING_RESET  = 8'd255;
	localparam logic [9:0] DEBOUNCE_RESET = 10'd50;
	localparam logic [9:0] INTERVAL_RESET = 10'd100;

	// Light mode codes
	localparam logic [1:0] LIGHT_RED   = 2'd0;
	localparam logic [1:0] LIGHT_WHITE = 2'd1;
	localparam logic [1:0] LIGHT_OFF   = 2'd2;

	// Quadrature table indexed by {previous pair, current pair}: +1, -1 or 0
	localparam logic [1:0] QUAD_TABLE [16] = '{
		2'b00, 2'b11, 2'b01, 2'b00,
		2'b01, 2'b00, 2'b00, 2'b11,
		2'b11, 2'b00, 2'b00, 2'b01,
		2'b00, 2'b01, 2'b11, 2'b00
	};

	typedef struct packed {
		logic [2:0] pulses_per_step;
		logic [7:0] step_size;
		logic [7:0] brightness_floor;
		logic [7:0] brightness_ceiling;
		logic [9:0] debounce_ticks;
		logic [9:0] send_interval_ticks;
	} cfg_t;

	typedef struct packed {
		logic [1:0] light_mode;
		logic       mode_strobe;
	} btn_res_t;

	typedef struct packed {
		logic [7:0] level;
		logic       level_strobe;
	} lvl_res_t;

	// Saturating tick increment
	function automatic logic [10:0] tick_up(input logic [10:0] c);
		return (c < TICK_MAX) ? c + 11'd1 : TICK_MAX;
	endfunction

endpackage

@@ hw/rtl/ekl_button.sv @@
`timescale 1ns / 1ps

module ekl_button import ekl_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     en,
	input  logic     button_level,
	input  cfg_t     cfg,
	output btn_res_t res
);

	logic        raw_prev_q;
	logic        stable_q;
	logic [10:0] since_change_q;
	logic [1:0]  mode_q;

	logic        stable_d;
	logic [10:0] since_change_d;
	logic [1:0]  mode_d;
	logic        strobe_d;

	// Debounce the button and advance the mode on a settled press
	always_comb begin
		since_change_d = tick_up(since_change_q);
		stable_d       = stable_q;
		mode_d         = mode_q;
		strobe_d       = 1'b0;
		if (button_level != raw_prev_q) begin
			since_change_d = '0;
		end
		if ((since_change_d > {1'b0, cfg.debounce_ticks}) && (button_level != stable_q)) begin
			stable_d = button_level;
			if (!button_level) begin
				strobe_d = 1'b1;
				case (mode_q)
					LIGHT_RED:   mode_d = LIGHT_WHITE;
					LIGHT_WHITE: mode_d = LIGHT_OFF;
					default:     mode_d = LIGHT_RED;
				endcase
			end
		end
	end

	// Commit state on each request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			raw_prev_q     <= 1'b1;
			stable_q       <= 1'b1;
			since_change_q <= '0;
			mode_q         <= LIGHT_RED;
		end else if (en) begin
			raw_prev_q     <= button_level;
			stable_q       <= stable_d;
			since_change_q <= since_change_d;
			mode_q         <= mode_d;
		end
	end

	assign res.light_mode  = mode_d;
	assign res.mode_strobe = strobe_d;

	a_press_settles: assert property (@(posedge clk) disable iff (!arst_n)
		(en && strobe_d) |=> (!stable_q && !raw_prev_q))
		else $error("mode advanced without a settled press");

	a_mode_code: assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q == LIGHT_RED) || (mode_q == LIGHT_WHITE) || (mode_q == LIGHT_OFF))
		else $error("mode register left the red/white/off cycle");

	a_strobe_on_press: assert property (@(posedge clk) disable iff (!arst_n)
		(en && strobe_d) |-> !button_level)
		else $error("mode advanced on a release");

endmodule

@@ hw/rtl/ekl_level.sv @@
`timescale 1ns / 1ps

module ekl_level import ekl_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     en,
	input  logic     pin_a,
	input  logic     pin_b,
	input  cfg_t     cfg,
	output lvl_res_t res
);

	logic [1:0]  prev_pair_q;
	logic [3:0]  accum_q;
	logic [7:0]  level_q;
	logic        pending_q;
	logic [10:0] since_send_q;

	logic [1:0]        pair;
	logic [1:0]        delta;
	logic signed [4:0] acc_sum;
	logic signed [4:0] acc_sat;
	logic signed [4:0] pps;
	logic signed [4:0] pps_neg;
	logic [3:0]        accum_d;
	logic              step_up;
	logic              step_dn;
	logic signed [9:0] nl;
	logic signed [9:0] floor_s;
	logic signed [9:0] ceil_s;
	logic signed [9:0] nl_clamp;
	logic [7:0]        level_d;
	logic              pend_step;
	logic              pending_d;
	logic [10:0]       since_send_d;
	logic              strobe_d;

	assign pair  = {pin_a, pin_b};
	assign delta = QUAD_TABLE[{prev_pair_q, pair}];

	// Decode the pair and saturate the accumulator to 4 signed bits
	always_comb begin
		acc_sum = {accum_q[3], accum_q} + {{3{delta[1]}}, delta};
		if (acc_sum > 5'sd7) begin
			acc_sat = 5'sd7;
		end else if (acc_sum < -5'sd8) begin
			acc_sat = -5'sd8;
		end else begin
			acc_sat = acc_sum;
		end
	end

	// Take at most one brightness step per request
	always_comb begin
		pps     = (cfg.pulses_per_step == 3'd0) ? 5'sd1 : {2'b00, cfg.pulses_per_step};
		pps_neg = -pps;
		step_up = 1'b0;
		step_dn = 1'b0;
		accum_d = acc_sat[3:0];
		if (acc_sat >= pps) begin
			step_up = 1'b1;
			accum_d = 4'(acc_sat - pps);
		end else if (acc_sat <= pps_neg) begin
			step_dn = 1'b1;
			accum_d = 4'(acc_sat + pps);
		end
	end

	// Move and clamp the brightness; floor is tested first
	always_comb begin
		floor_s = {2'b00, cfg.brightness_floor};
		ceil_s  = {2'b00, cfg.brightness_ceiling};
		if (step_dn) begin
			nl = {2'b00, level_q} - {2'b00, cfg.step_size};
		end else begin
			nl = {2'b00, level_q} + {2'b00, cfg.step_size};
		end
		if (nl < floor_s) begin
			nl_clamp = floor_s;
		end else if (nl > ceil_s) begin
			nl_clamp = ceil_s;
		end else begin
			nl_clamp = nl;
		end
		level_d   = level_q;
		pend_step = pending_q;
		if ((step_up || step_dn) && (nl_clamp[7:0] != level_q)) begin
			level_d   = nl_clamp[7:0];
			pend_step = 1'b1;
		end
	end

	// Throttle sends by the interval counter
	always_comb begin
		since_send_d = tick_up(since_send_q);
		pending_d    = pend_step;
		strobe_d     = 1'b0;
		if (pend_step && (since_send_d >= {1'b0, cfg.send_interval_ticks})) begin
			since_send_d = '0;
			pending_d    = 1'b0;
			strobe_d     = 1'b1;
		end
	end

	// Commit state on each request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_pair_q  <= '0;
			accum_q      <= '0;
			level_q      <= DEFAULT_LEVEL;
			pending_q    <= 1'b0;
			since_send_q <= '0;
		end else if (en) begin
			prev_pair_q  <= pair;
			accum_q      <= accum_d;
			level_q      <= level_d;
			pending_q    <= pending_d;
			since_send_q <= since_send_d;
		end
	end

	assign res.level        = level_d;
	assign res.level_strobe = strobe_d;

	a_send_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(en && strobe_d) |=> (since_send_q == '0 && !pending_q))
		else $error("send did not restart the interval");

	a_level_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(en && !pending_q && !step_up && !step_dn) |=> $stable(level_q))
		else $error("brightness moved without a step");

	a_one_direction: assert property (@(posedge clk) disable iff (!arst_n)
		!(step_up && step_dn))
		else $error("step taken in both directions");

endmodule

@@ hw/rtl/encoder_knob_light_controller.sv @@
`timescale 1ns / 1ps

// Rotary encoder knob light controller. One request is one tick: sampled
// encoder levels pin_a/pin_b and the active-low button_level. Each tick
// yields exactly one result with the mode (red, white, off), the brightness
// after the tick and two strobes: mode_strobe on a debounced press,
// level_strobe on a throttled brightness send. A request is registered,
// decoded and its result registered, so a new request is taken every
// cycle while the input does not stall; the result register loads when the
// request advances out of the input register. The result register holds
// while out_stall is high, and the input stalls only when both the input
// and result registers are full and out_stall is high. Configuration
// writes are always ready and must be issued while no tick is in flight.

module encoder_knob_light_controller import ekl_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	// tick input
	input  logic       in_valid,
	output logic       in_stall,
	input  logic       pin_a,
	input  logic       pin_b,
	input  logic       button_level,
	// result output
	output logic       out_valid,
	input  logic       out_stall,
	output logic [1:0] light_mode,
	output logic [7:0] level,
	output logic       mode_strobe,
	output logic       level_strobe,
	// configuration writes
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [2:0] cfg_index,
	input  logic [9:0] cfg_data
);

	cfg_t     cfg_q;
	btn_res_t btn_res;
	lvl_res_t lvl_res;

	logic valid_s1;
	logic pin_a_s1;
	logic pin_b_s1;
	logic button_s1;
	logic valid_s2;
	logic advance;

	assign cfg_ready = 1'b1;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pulses_per_step     <= PPS_RESET;
			cfg_q.step_size           <= STEP_RESET;
			cfg_q.brightness_floor    <= FLOOR_RESET;
			cfg_q.brightness_ceiling  <= CEILING_RESET;
			cfg_q.debounce_ticks      <= DEBOUNCE_RESET;
			cfg_q.send_interval_ticks <= INTERVAL_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_PULSES_PER_STEP:     cfg_q.pulses_per_step     <= cfg_data[2:0];
				REG_STEP_SIZE:           cfg_q.step_size           <= cfg_data[7:0];
				REG_BRIGHTNESS_FLOOR:    cfg_q.brightness_floor    <= cfg_data[7:0];
				REG_BRIGHTNESS_CEILING:  cfg_q.brightness_ceiling  <= cfg_data[7:0];
				REG_DEBOUNCE_TICKS:      cfg_q.debounce_ticks      <= cfg_data;
				REG_SEND_INTERVAL_TICKS: cfg_q.send_interval_ticks <= cfg_data;
				default: ;
			endcase
		end
	end

	// Advance the input stage when the result register is free or draining
	assign advance  = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall = valid_s1 && !advance;

	// Capture the request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			pin_a_s1  <= pin_a;
			pin_b_s1  <= pin_b;
			button_s1 <= button_level;
		end
	end

	ekl_button u_button (
		.clk          (clk),
		.arst_n       (arst_n),
		.en           (advance),
		.button_level (button_s1),
		.cfg          (cfg_q),
		.res          (btn_res)
	);

	ekl_level u_level (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (advance),
		.pin_a  (pin_a_s1),
		.pin_b  (pin_b_s1),
		.cfg    (cfg_q),
		.res    (lvl_res)
	);

	// Result register: load on advance, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (!out_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			light_mode   <= btn_res.light_mode;
			mode_strobe  <= btn_res.mode_strobe;
			level        <= lvl_res.level;
			level_strobe <= lvl_res.level_strobe;
		end
	end

	assign out_valid = valid_s2;

	a_stall_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && valid_s2 && out_stall))
		else $error("input stalled with room in the pipeline");

	a_advance_fills: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> valid_s2)
		else $error("decoded tick lost before the result register");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && out_stall) |-> !advance || !valid_s2 || !out_stall)
		else $error("stalled result overwritten");

endmodule

@@ test/encoder_knob_light_controller_test.sv @@
`timescale 1ns / 1ps

module encoder_knob_light_controller_test;
	import ekl_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int HOLDOFF_CYCLES = 300;
	localparam int DRAIN_CYCLES = 4;

	// Step of the quadrature count for {previous pair, current pair}
	localparam int QUAD_DELTA [16] = '{
		0, -1, 1, 0,
		1, 0, 0, -1,
		-1, 0, 0, 1,
		0, 1, -1, 0
	};

	// Encoder positions in rotation order
	localparam logic [1:0] GRAY_SEQ [4] = '{2'b00, 2'b01, 2'b11, 2'b10};

	// Pair sequence that walks every one of the sixteen transitions from reset
	localparam logic [1:0] PAIR_SWEEP [16] = '{
		2'd0, 2'd1, 2'd0, 2'd2, 2'd0, 2'd3, 2'd1, 2'd1,
		2'd2, 2'd1, 2'd3, 2'd2, 2'd2, 2'd3, 2'd3, 2'd0
	};

	typedef struct packed {
		logic a;
		logic b;
		logic btn;
	} tick_t;

	typedef struct packed {
		logic [1:0] light_mode;
		logic [7:0] level;
		logic       mode_strobe;
		logic       level_strobe;
	} light_result_t;

	logic       clk = 1'b0;
	logic       arst_n;
	logic       in_valid;
	logic       in_stall;
	logic       pin_a;
	logic       pin_b;
	logic       button_level;
	logic       out_valid;
	logic       out_stall;
	logic [1:0] light_mode;
	logic [7:0] level;
	logic       mode_strobe;
	logic       level_strobe;
	logic       cfg_valid;
	logic       cfg_ready;
	logic [2:0] cfg_index;
	logic [9:0] cfg_data;

	encoder_knob_light_controller u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.pin_a        (pin_a),
		.pin_b        (pin_b),
		.button_level (button_level),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.light_mode   (light_mode),
		.level        (level),
		.mode_strobe  (mode_strobe),
		.level_strobe (level_strobe),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	// Knob settings as the block should hold them
	int cfg_pps;
	int cfg_step;
	int cfg_floor;
	int cfg_ceiling;
	int cfg_debounce;
	int cfg_interval;

	// Knob state as the block should hold it
	logic [1:0] enc_prev_pair;
	int         enc_accum;
	logic [7:0] knob_level;
	logic [1:0] knob_mode;
	logic       btn_raw;
	logic       btn_stable;
	int         btn_since;
	logic       send_due;
	int         send_since;

	// Request stream and results still owed by the block
	tick_t         ticks_pending[$];
	light_result_t light_results_due[$];
	int            ticks_queued;
	int            ticks_accepted;
	int            results_seen;
	int            fail_count;
	int            cycle_count;

	// Idling and hold-off controls
	int   send_gap_pct;
	int   recv_stall_pct;
	logic hold_recv;
	bit   holdoff_arm;

	// Encoder and button stimulus state
	int   gen_pos;
	int   gen_dir;
	logic gen_btn;
	int   gen_run;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic void reset_knob_model();
		cfg_pps = PPS_RESET;
		cfg_step = STEP_RESET;
		cfg_floor = FLOOR_RESET;
		cfg_ceiling = CEILING_RESET;
		cfg_debounce = DEBOUNCE_RESET;
		cfg_interval = INTERVAL_RESET;
		enc_prev_pair = 2'b00;
		enc_accum = 0;
		knob_level = DEFAULT_LEVEL;
		knob_mode = LIGHT_RED;
		btn_raw = 1'b1;
		btn_stable = 1'b1;
		btn_since = 0;
		send_due = 1'b0;
		send_since = 0;
	endfunction

	// Advance the knob by one tick and return what the block should report
	function automatic light_result_t advance_knob(tick_t t);
		light_result_t r;
		logic [1:0]    pair;
		int            pps;
		int            step_dir;
		int            nl;
		r = '0;
		pair = {t.a, t.b};
		pps = (cfg_pps == 0) ? 1 : cfg_pps;
		step_dir = 0;

		btn_since = (btn_since < 2047) ? btn_since + 1 : 2047;
		send_since = (send_since < 2047) ? send_since + 1 : 2047;

		// count quadrature pulses, saturating at the 4-bit signed range
		enc_accum += QUAD_DELTA[{enc_prev_pair, pair}];
		if (enc_accum > 7)
			enc_accum = 7;
		if (enc_accum < -8)
			enc_accum = -8;
		enc_prev_pair = pair;

		// debounce the button; a settled press cycles the mode
		if (t.btn != btn_raw) begin
			btn_since = 0;
			btn_raw = t.btn;
		end
		if (btn_since > cfg_debounce && t.btn != btn_stable) begin
			btn_stable = t.btn;
			if (!btn_stable) begin
				knob_mode = (knob_mode >= LIGHT_OFF) ? LIGHT_RED : knob_mode + 2'd1;
				r.mode_strobe = 1'b1;
			end
		end

		// take at most one brightness step per tick
		if (enc_accum >= pps) begin
			step_dir = 1;
			enc_accum -= pps;
		end else if (enc_accum <= -pps) begin
			step_dir = -1;
			enc_accum += pps;
		end
		if (step_dir != 0) begin
			nl = int'(knob_level) + step_dir * cfg_step;
			if (nl < cfg_floor)
				nl = cfg_floor;
			else if (nl > cfg_ceiling)
				nl = cfg_ceiling;
			if (nl != int'(knob_level)) begin
				knob_level = nl[7:0];
				send_due = 1'b1;
			end
		end

		// issue a throttled brightness send
		if (send_due && send_since >= cfg_interval) begin
			send_since = 0;
			send_due = 1'b0;
			r.level_strobe = 1'b1;
		end

		r.light_mode = knob_mode;
		r.level = knob_level;
		return r;
	endfunction

	// Write one register and mirror it once the block takes it
	task automatic write_knob_reg(input logic [2:0] idx, input int value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value[9:0];
		do
			@(posedge clk);
		while (cfg_ready !== 1'b1);
		case (idx)
			REG_PULSES_PER_STEP:     cfg_pps = value & 7;
			REG_STEP_SIZE:           cfg_step = value & 8'hFF;
			REG_BRIGHTNESS_FLOOR:    cfg_floor = value & 8'hFF;
			REG_BRIGHTNESS_CEILING:  cfg_ceiling = value & 8'hFF;
			REG_DEBOUNCE_TICKS:      cfg_debounce = value & 10'h3FF;
			REG_SEND_INTERVAL_TICKS: cfg_interval = value & 10'h3FF;
			default: ;
		endcase
	endtask

	task automatic set_knobs(input int pps, input int step, input int floor_lvl,
			input int ceil_lvl, input int debounce, input int interval);
		write_knob_reg(REG_PULSES_PER_STEP, pps);
		write_knob_reg(REG_STEP_SIZE, step);
		write_knob_reg(REG_BRIGHTNESS_FLOOR, floor_lvl);
		write_knob_reg(REG_BRIGHTNESS_CEILING, ceil_lvl);
		write_knob_reg(REG_DEBOUNCE_TICKS, debounce);
		write_knob_reg(REG_SEND_INTERVAL_TICKS, interval);
		cfg_valid <= 1'b0;
	endtask

	// Queue encoder rotation with reversals, double jumps and noise, plus
	// button holds of up to twice the debounce plus 20 ticks, and some short bounces
	task automatic queue_ticks(input int count);
		tick_t t;
		int    roll;
		repeat (count) begin
			roll = $urandom_range(99);
			if (roll < 6)
				gen_pos = (gen_pos + 2) % 4;
			else if (roll < 10)
				gen_pos = $urandom_range(3);
			else if (roll >= 25)
				gen_pos = (gen_pos + gen_dir) % 4;
			if ($urandom_range(99) < 4)
				gen_dir = 4 - gen_dir;
			if (gen_run == 0) begin
				gen_btn = !gen_btn;
				if ($urandom_range(99) < 25)
					gen_run = $urandom_range(1, 3);
				else
					gen_run = $urandom_range(1, 2 * cfg_debounce + 20);
			end
			gen_run--;
			{t.a, t.b} = GRAY_SEQ[gen_pos];
			t.btn = gen_btn;
			ticks_pending.push_back(t);
			ticks_queued++;
		end
	endtask

	// Wait until every request is taken and every result is back
	task automatic drain_results();
		do
			@(posedge clk);
		while (ticks_accepted != ticks_queued || light_results_due.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic run_phase(input int gap_pct, input int stall_pct, input int count);
		send_gap_pct = gap_pct;
		recv_stall_pct = stall_pct;
		queue_ticks(count);
		drain_results();
	endtask

	// Request driver: predict on acceptance, hold while stalled, then offer
	always @(posedge clk) begin
		if (in_valid && !in_stall) begin
			light_results_due.push_back(advance_knob({pin_a, pin_b, button_level}));
			ticks_accepted++;
		end
		if (!(in_valid && in_stall)) begin
			if (arst_n && ticks_pending.size() != 0 &&
					$urandom_range(99) >= send_gap_pct) begin
				tick_t t;
				t = ticks_pending.pop_front();
				in_valid <= 1'b1;
				pin_a <= t.a;
				pin_b <= t.b;
				button_level <= t.btn;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Result monitor: compare against the oldest owed result, then stall at random
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			results_seen++;
			if (light_results_due.size() == 0) begin
				fail_count++;
				if (fail_count <= 10)
					$display("%0t: unexpected result %0d: mode %0d level %0d strobes %b%b",
						$realtime, results_seen, light_mode, level, mode_strobe,
						level_strobe);
			end else begin
				light_result_t exp_r;
				exp_r = light_results_due.pop_front();
				if (exp_r.light_mode !== light_mode || exp_r.level !== level ||
						exp_r.mode_strobe !== mode_strobe ||
						exp_r.level_strobe !== level_strobe) begin
					fail_count++;
					if (fail_count <= 10)
						$display("%0t: result %0d: expected mode %0d level %0d strobes %b%b, got mode %0d level %0d strobes %b%b",
							$realtime, results_seen, exp_r.light_mode, exp_r.level,
							exp_r.mode_strobe, exp_r.level_strobe, light_mode, level,
							mode_strobe, level_strobe);
				end
			end
		end
		out_stall <= hold_recv || ($urandom_range(99) < recv_stall_pct);
	end

	// Long receiver hold-off so the block fills and stalls its input
	initial begin
		hold_recv = 1'b0;
		wait (holdoff_arm);
		@(posedge clk);
		hold_recv <= 1'b1;
		repeat (HOLDOFF_CYCLES) @(posedge clk);
		hold_recv <= 1'b0;
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("encoder_knob_light_controller: mismatch");
			$finish;
		end
	end

	initial begin
		tick_t t;
		arst_n = 1'b0;
		in_valid = 1'b0;
		pin_a = 1'b0;
		pin_b = 1'b0;
		button_level = 1'b1;
		out_stall = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = REG_PULSES_PER_STEP;
		cfg_data = '0;
		send_gap_pct = 0;
		recv_stall_pct = 0;
		holdoff_arm = 1'b0;
		ticks_queued = 0;
		ticks_accepted = 0;
		results_seen = 0;
		fail_count = 0;
		cycle_count = 0;
		gen_pos = 0;
		gen_dir = 1;
		gen_btn = 1'b1;
		gen_run = 0;
		reset_knob_model();

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// walk every pair transition with the button chattering
		for (int i = 0; i < 16; i++) begin
			{t.a, t.b} = PAIR_SWEEP[i];
			t.btn = (i % 3) != 0;
			ticks_pending.push_back(t);
			ticks_queued++;
		end
		gen_pos = 0;
		run_phase(0, 0, 150);

		// widest clamp, biggest step, single-pulse steps, no debounce or throttle
		set_knobs(1, 255, 0, 255, 0, 0);
		run_phase(77, 0, 150);

		// zero pulses per step, floor above ceiling
		set_knobs(0, 1, 200, 50, 3, 5);
		run_phase(0, 77, 150);

		set_knobs(4, 37, 10, 240, 10, 20);
		run_phase(20, 20, 200);

		// lower the pulse count after a coarse setting and hold off the receiver
		set_knobs(1, 3, 0, 255, 5, 1);
		holdoff_arm = 1'b1;
		run_phase(0, 0, 150);

		// longest debounce and send interval
		set_knobs(2, 128, 0, 255, 1023, 1023);
		run_phase(0, 0, 250);

		// random settings across the idling mixes
		for (int p = 0; p < 3; p++) begin
			set_knobs($urandom_range(0, 4), $urandom_range(1, 255), $urandom_range(255),
				$urandom_range(255), $urandom_range(60), $urandom_range(200));
			case (p)
				0: run_phase(77, 0, 100);
				1: run_phase(0, 77, 100);
				default: run_phase(20, 20, 100);
			endcase
		end

		if (fail_count == 0 && light_results_due.size() == 0)
			$display("encoder_knob_light_controller: match");
		else
			$display("encoder_knob_light_controller: mismatch");
		$finish;
	end

endmodule
